// ===== rtl/core/pmfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmfp_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [7:0] TRAILER_BYTE = 8'hFF;

    // frame position: hunting, then count of frame bytes taken so far
    localparam logic [2:0] POS_HUNT     = 3'd0;
    localparam logic [2:0] POS_LAST_PM  = 3'd4;
    localparam logic [2:0] POS_CHECKSUM = 3'd5;
    localparam logic [2:0] POS_TRAILER  = 3'd6;
    localparam logic [2:0] POS_UNUSED   = 3'd7;

    typedef enum logic [1:0] {
        ST_VALID       = 2'd0,
        ST_BAD_TRAILER = 2'd1,
        ST_BAD_SUM     = 2'd2
    } frame_status_t;

    // one received byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } rx_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pmfp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmfp_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    output pmfp_pkg::rx_item_t     item,
    input  wire logic              item_take
);
    import pmfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // free, or emptied in this same cycle
    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

    a_take_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take |-> valid_reg)
        else $error("input register taken while empty");

endmodule

`default_nettype wire

// ===== rtl/core/pmfp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmfp_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pmfp_pkg::rx_item_t item,
    output logic                   item_take,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,
    output logic [1:0]             m_tuser
);
    import pmfp_pkg::*;

    logic [2:0]    pos_reg, pos_next;
    logic [7:0]    sum_reg, sum_next;
    logic          matched_reg, matched_next;
    logic [7:0]    payload_reg [4];
    logic [1:0]    payload_idx;
    logic [15:0]   pm25_held_reg, pm25_held_next;
    logic [15:0]   pm10_held_reg, pm10_held_next;
    logic          out_valid_reg, out_valid_next;
    frame_status_t out_status_reg, status_next;
    logic [15:0]   out_pm25_reg, out_pm10_reg;
    logic          out_free;
    logic          emit;
    logic [2:0]    pos_less_one;

    assign out_free = !out_valid_reg || m_tready;
    // only the trailer byte needs room in the result register
    assign item_take = item.valid && ((pos_reg != POS_TRAILER) || out_free);
    assign emit = item_take && (pos_reg == POS_TRAILER);
    assign pos_less_one = pos_reg - 3'd1;
    assign payload_idx  = pos_less_one[1:0];

    always_comb begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        matched_next   = matched_reg;
        pm25_held_next = pm25_held_reg;
        pm10_held_next = pm10_held_reg;
        status_next    = ST_VALID;
        if (item_take) begin
            if (pos_reg == POS_HUNT || pos_reg == POS_UNUSED) begin
                pos_next = POS_HUNT;
                if (item.rx_byte == HEADER_BYTE) begin
                    sum_next     = 8'd0;
                    matched_next = 1'b0;
                    pos_next     = 3'd1;
                end
            end else if (pos_reg <= POS_LAST_PM) begin
                sum_next = sum_reg + item.rx_byte;
                pos_next = pos_reg + 3'd1;
            end else if (pos_reg == POS_CHECKSUM) begin
                matched_next = (item.rx_byte == sum_reg);
                pos_next     = POS_TRAILER;
            end else begin
                pos_next = POS_HUNT;
                if (item.rx_byte != TRAILER_BYTE) begin
                    status_next = ST_BAD_TRAILER;
                end else if (!matched_reg) begin
                    status_next = ST_BAD_SUM;
                end else begin
                    status_next    = ST_VALID;
                    pm25_held_next = {payload_reg[0], payload_reg[1]};
                    pm10_held_next = {payload_reg[2], payload_reg[3]};
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_HUNT;
            sum_reg       <= 8'd0;
            matched_reg   <= 1'b0;
            pm25_held_reg <= 16'd0;
            pm10_held_reg <= 16'd0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            matched_reg   <= matched_next;
            pm25_held_reg <= pm25_held_next;
            pm10_held_reg <= pm10_held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && pos_reg != POS_HUNT && pos_reg <= POS_LAST_PM) begin
            payload_reg[payload_idx] <= item.rx_byte;
        end
        if (emit) begin
            out_status_reg <= status_next;
            out_pm25_reg   <= pm25_held_next;
            out_pm10_reg   <= pm10_held_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pm10_reg, out_pm25_reg};
    assign m_tuser  = out_status_reg;

    a_result_from_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(pos_reg == POS_TRAILER))
        else $error("result raised without a trailer byte");

    a_pos_reachable: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != POS_UNUSED)
        else $error("frame position reached unused value");

    a_held_only_on_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$stable(pm25_held_reg) || !$stable(pm10_held_reg))
            |-> (out_valid_reg && out_status_reg == ST_VALID))
        else $error("held readings changed without a valid frame");

    a_trailer_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> pos_reg == POS_HUNT)
        else $error("position not back to hunting after trailer");

endmodule

`default_nettype wire

// ===== rtl/core/pm_sensor_frame_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// particulate sensor serial frame parser
// s_ channel: one received serial byte per item; non-header bytes are dropped
// while hunting for the 0xaa header, then six more bytes form a frame:
// pm2.5 high/low, pm10 high/low, 8-bit sum checksum, 0xff trailer
// m_ channel: one item per seven-byte frame, taken on the trailer byte
//   m_tuser = frame status (0 valid, 1 trailer wrong, 2 checksum wrong;
//   trailer checked first)
//   m_tdata = last valid pm2.5 and pm10 readings in tenths
// throughput: one byte per cycle, set by the single input register and
// result register with the position counter and 8-bit adder between them
// a trailer byte passes through the input register and is loaded into the
// result register when the parser takes it, which raises m_tvalid
// when the receiver stalls, the result waits in the result register and the
// input register still takes one more byte; header and payload bytes keep
// flowing, only a trailer byte waits for the result register to empty
// reset (aresetn low, synchronous) returns to hunting, clears the checksum
// state and sets both held readings to zero

module pm_sensor_frame_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] pm25_tenths, [31:16] pm10_tenths
    output logic [1:0]       m_tuser    // [1:0] frame_status
);
    import pmfp_pkg::*;

    rx_item_t rx_item;
    logic     rx_take;

    // input register: holds one byte ahead of the parser
    pmfp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .item      (rx_item),
        .item_take (rx_take)
    );

    // frame tracking, checksum, held readings and result register
    pmfp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (rx_item),
        .item_take (rx_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_out_needs_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(rx_take))
        else $error("result appeared without a byte taken");

    a_take_clears_or_refills: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_take && !(s_tvalid && s_tready)) |=> !rx_item.valid)
        else $error("input register not emptied after take");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pmfp_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int REPORT_CAP = 50;

    typedef struct packed {
        frame_status_t status;
        logic [15:0]   pm25;
        logic [15:0]   pm10;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;

    // parser state mirror
    logic [2:0]    frame_pos = POS_HUNT;
    logic [7:0]    payload [4];
    logic [7:0]    byte_sum = 8'h00;
    logic          sum_ok = 1'b0;
    logic [15:0]   pm25_held = 16'h0000;
    logic [15:0]   pm10_held = 16'h0000;
    frame_result_t readings_due [$];

    always #2 aclk = ~aclk;

    pm_sensor_frame_parser_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < REPORT_CAP)
            $display("%0t ns: %s: got %0h, wanted %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // advance the mirrored parser by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] rx_byte);
        frame_result_t res;
        if (frame_pos > POS_HUNT && frame_pos <= POS_LAST_PM) begin
            payload[2'(frame_pos - 3'd1)] = rx_byte;
            byte_sum = byte_sum + rx_byte;
            frame_pos = frame_pos + 3'd1;
        end else if (frame_pos == POS_CHECKSUM) begin
            sum_ok = (rx_byte == byte_sum);
            frame_pos = POS_TRAILER;
        end else if (frame_pos == POS_TRAILER) begin
            if (rx_byte != TRAILER_BYTE) begin
                res.status = ST_BAD_TRAILER;
            end else if (!sum_ok) begin
                res.status = ST_BAD_SUM;
            end else begin
                res.status = ST_VALID;
                pm25_held = {payload[0], payload[1]};
                pm10_held = {payload[2], payload[3]};
            end
            res.pm25 = pm25_held;
            res.pm10 = pm10_held;
            readings_due.push_back(res);
            frame_pos = POS_HUNT;
        end else begin
            // hunting, and the unreachable position as well
            frame_pos = POS_HUNT;
            if (rx_byte == HEADER_BYTE) begin
                byte_sum = 8'h00;
                sum_ok = 1'b0;
                frame_pos = 3'd1;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] rx_byte);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx_byte;
        do @(posedge aclk); while (!s_tready);
        parse_rx_byte(rx_byte);
    endtask

    // readings packed high byte first: pm2.5 hi, pm2.5 lo, pm10 hi, pm10 lo
    task automatic send_frame(input logic [31:0] readings, input logic [7:0] sum_skew,
                              input logic [7:0] trailer);
        logic [7:0] sum;
        sum = readings[31:24] + readings[23:16] + readings[15:8] + readings[7:0];
        send_byte(HEADER_BYTE);
        send_byte(readings[31:24]);
        send_byte(readings[23:16]);
        send_byte(readings[15:8]);
        send_byte(readings[7:0]);
        send_byte(sum + sum_skew);
        send_byte(trailer);
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_hunting_and_extremes;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_byte(8'h00);                                   // dropped while hunting
        // header and trailer values as data, sum wraps past 256
        send_frame(32'hFFFF_AAAA, 8'h00, TRAILER_BYTE);
    endtask

    task automatic test_bad_frames;
        send_frame(32'h0000_0000, 8'h01, TRAILER_BYTE);     // checksum wrong
        send_frame(32'h1234_5678, 8'h01, 8'h00);            // both wrong, trailer wins
        wait_results_drained;
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int n_items);
        int          frame_bytes;
        int          pick;
        logic [31:0] readings;
        frame_bytes = 0;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (frame_bytes < n_items) begin
            case ($urandom_range(0, 7))
                0:       readings = 32'h0000_0000;
                1:       readings = 32'hFFFF_FFFF;
                default: readings = $urandom;
            endcase
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                send_frame(readings, 8'h00, TRAILER_BYTE);
            end else if (pick == 6) begin
                send_frame(readings, 8'($urandom_range(1, 255)), TRAILER_BYTE);
            end else if (pick == 7) begin
                send_frame(readings, 8'h00, 8'($urandom_range(0, 254)));
            end else if (pick == 8) begin
                send_frame(readings, 8'($urandom_range(1, 255)),
                           8'($urandom_range(0, 254)));
            end else begin
                // line noise, may open a frame of its own
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                frame_bytes -= 7;
            end
            frame_bytes += 7;
        end
        wait_results_drained;
    endtask

    // result side: random stalls, compare each taken item with the oldest due
    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result with none due", m_tdata, 32'h0);
                end else begin
                    want = readings_due.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("frame status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[15:0] !== want.pm25)
                        report_mismatch("pm2.5 tenths", 32'(m_tdata[15:0]),
                                        32'(want.pm25));
                    if (m_tdata[31:16] !== want.pm10)
                        report_mismatch("pm10 tenths", 32'(m_tdata[31:16]),
                                        32'(want.pm10));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_hunting_and_extremes;
        test_bad_frames;
        test_random_frames(0, 0, 150);
        test_random_frames(59, 0, 150);
        test_random_frames(0, 59, 150);
        test_random_frames(23, 23, 150);
        repeat (4) @(posedge aclk);
        if (error_count == 0 && readings_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pmfp_pkg.sv
rtl/core/pmfp_in_stage.sv
rtl/core/pmfp_parse.sv
rtl/core/pm_sensor_frame_parser_core.sv
sim/tb.sv
